// ----- rtl/lpht_pkg.sv -----
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants for the linear probe hash table
// Slot kinds, operation codes, widths and the front-to-back request word.
// ----------------------------------------------------------------------------
`default_nettype none
package lpht_pkg;
    localparam int SLOTS       = 256;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int KEY_W       = 32;
    localparam int VALUE_W     = 64;
    localparam int COUNT_W     = SLOT_W + 1;
    localparam int LIMIT_W     = 8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd192;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_DELETE = 2'd2;
    localparam logic [1:0] MODE_CLEAR  = 2'd3;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_LIVE  = 2'd1;
    localparam logic [1:0] KIND_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [KEY_W-1:0]   key_id;
        logic [SLOT_W-1:0]  home_slot;
        logic [VALUE_W-1:0] new_value;
    } t_req;
endpackage
`default_nettype wire

// ----- rtl/linear_probe_hash_table.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_table: open-addressing table with linear probing
// Insert, lookup, delete and clear with tombstone reuse and a load limit.
// ----------------------------------------------------------------------------
// channel | signals                                  | direction
// cfg     | i_cfg_we, i_cfg_data (entry_limit)       | in
// request | i_valid/o_stall, mode,key,home,value     | in
// result  | o_valid/i_stall, hit,read_value,status   | out
//
// Each probe step is a registered slot RAM read, then a compare; the result
// is valid after the compare that ends the probe, and a lookup hit adds a
// data RAM read first. The engine takes its next word only once the result
// has been taken, and a word reaching an idle engine passes through the
// registered queue first.
// Clear, and reset, sweep the 256-entry kind RAM and take no items meanwhile.
// A two-word queue keeps taking requests until it is full while the engine
// works or the result waits under stall; the engine holds a finished word until taken.
`default_nettype none
module linear_probe_hash_table (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [lpht_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [1:0]                      i_mode,
    input  wire logic [lpht_pkg::KEY_W-1:0]      i_key_id,
    input  wire logic [lpht_pkg::SLOT_W-1:0]     i_home_slot,
    input  wire logic [lpht_pkg::VALUE_W-1:0]    i_new_value,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_hit,
    output logic [lpht_pkg::VALUE_W-1:0]         o_read_value,
    output logic                                 o_status
);
    logic [lpht_pkg::LIMIT_W-1:0] r_limit;
    lpht_pkg::t_req               in_req, q_req;
    logic                         q_valid, q_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= lpht_pkg::LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    assign in_req = '{mode: i_mode, key_id: i_key_id, home_slot: i_home_slot,
                      new_value: i_new_value};

    lpht_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_req(in_req),
        .o_valid(q_valid), .i_take(q_take), .o_req(q_req));

    lpht_back u_back (
        .i_clk, .i_rst_n, .i_req_valid(q_valid), .o_req_take(q_take),
        .i_req(q_req), .i_limit(r_limit), .o_valid, .i_stall,
        .o_hit, .o_read_value, .o_status);
endmodule
`default_nettype wire

// ----- rtl/lpht_ram.sv -----
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port-write, one-read RAM
// Read data registered one cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/lpht_front.sv -----
// ----------------------------------------------------------------------------
// lpht_front: input stage and two-entry request queue
// Accepts words, keeps them in a small FIFO for the probe engine.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire lpht_pkg::t_req  i_req,
    output logic                 o_valid,
    input  wire logic            i_take,
    output lpht_pkg::t_req       o_req
);
    lpht_pkg::t_req r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign push    = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign pop     = o_valid && i_take;
    assign o_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// ----- rtl/lpht_back.sv -----
// ----------------------------------------------------------------------------
// lpht_back: probe engine
// Walks slots from home, applies the operation, emits one result word.
// ----------------------------------------------------------------------------
`default_nettype none
module lpht_back (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_req_valid,
    output logic                                    o_req_take,
    input  wire lpht_pkg::t_req                     i_req,
    input  wire logic [lpht_pkg::LIMIT_W-1:0]       i_limit,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_hit,
    output logic [lpht_pkg::VALUE_W-1:0]            o_read_value,
    output logic                                    o_status
);
    localparam logic [2:0] ST_CLR   = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_EVAL  = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;

    localparam int SW = lpht_pkg::SLOT_W;

    logic [2:0]                        r_st;
    lpht_pkg::t_req                    r_req;
    logic [SW-1:0]                     r_idx, r_tomb_at, r_clr;
    logic [SW:0]                       r_n;
    logic                              r_tomb;
    logic [lpht_pkg::COUNT_W-1:0]      r_used;

    // kind memory with a clear sweep
    logic          kind_we;
    logic [SW-1:0] kind_wa, kind_ra, key_wa, data_ra;
    logic [1:0]    kind_wd, kind_rd;
    logic          key_we, data_we;
    logic [lpht_pkg::KEY_W-1:0]   key_rd;
    logic [lpht_pkg::VALUE_W-1:0] data_rd, data_wd;
    logic                         n_done, n_hit, n_status, n_rd;

    lpht_ram #(.WIDTH(2), .DEPTH(lpht_pkg::SLOTS)) u_kind (
        .i_clk, .i_we(kind_we), .i_waddr(kind_wa), .i_wdata(kind_wd),
        .i_raddr(kind_ra), .o_rdata(kind_rd));
    lpht_ram #(.WIDTH(lpht_pkg::KEY_W), .DEPTH(lpht_pkg::SLOTS)) u_key (
        .i_clk, .i_we(key_we), .i_waddr(key_wa), .i_wdata(r_req.key_id),
        .i_raddr(kind_ra), .o_rdata(key_rd));
    lpht_ram #(.WIDTH(lpht_pkg::VALUE_W), .DEPTH(lpht_pkg::SLOTS)) u_data (
        .i_clk, .i_we(data_we), .i_waddr(key_wa), .i_wdata(data_wd),
        .i_raddr(data_ra), .o_rdata(data_rd));

    assign kind_ra   = r_idx;
    assign data_ra   = r_idx;
    assign data_wd   = r_req.new_value;
    assign o_req_take = (r_st == ST_IDLE) && !o_valid;

    logic is_empty, is_found, full_ref;
    assign is_empty = (kind_rd == lpht_pkg::KIND_EMPTY);
    assign is_found = (kind_rd == lpht_pkg::KIND_LIVE) && (key_rd == r_req.key_id);
    assign full_ref = ({1'b0, r_used} + 10'd1) > {2'b0, i_limit};

    // write port decode for the clear sweep and the eval step
    always_comb begin
        kind_we = 1'b0; kind_wa = r_idx; kind_wd = lpht_pkg::KIND_LIVE;
        key_we  = 1'b0; data_we = 1'b0;  key_wa = r_idx;
        n_done  = 1'b0; n_hit = 1'b0; n_status = 1'b0; n_rd = 1'b0;
        if (r_st == ST_CLR) begin
            kind_we = 1'b1; kind_wa = r_clr; kind_wd = lpht_pkg::KIND_EMPTY;
        end else if (r_st == ST_EVAL) begin
            if (is_found) begin
                n_done = 1'b1;
                unique case (r_req.mode)
                    lpht_pkg::MODE_INSERT: data_we = 1'b1;
                    lpht_pkg::MODE_LOOKUP: begin n_hit = 1'b1; n_rd = 1'b1; end
                    lpht_pkg::MODE_DELETE: begin
                        n_hit = 1'b1; kind_we = 1'b1; kind_wd = lpht_pkg::KIND_TOMB;
                    end
                    default: ;
                endcase
            end else if (is_empty || r_n == 9'(lpht_pkg::SLOTS - 1)) begin
                n_done = 1'b1;
                if (r_req.mode == lpht_pkg::MODE_INSERT) begin
                    if (r_tomb) begin
                        key_wa = r_tomb_at; kind_wa = r_tomb_at;
                        kind_we = 1'b1; key_we = 1'b1; data_we = 1'b1; n_hit = 1'b1;
                    end else if (is_empty && !full_ref) begin
                        kind_we = 1'b1; key_we = 1'b1; data_we = 1'b1; n_hit = 1'b1;
                    end else begin
                        n_status = 1'b1;
                    end
                end
            end
        end
    end

    logic r_new_slot;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_CLR;
            r_clr      <= '0;
            o_valid    <= 1'b0;
            r_used     <= '0;
            r_new_slot <= 1'b0;
        end else begin
            if (o_valid && !i_stall) o_valid <= 1'b0;
            unique case (r_st)
                ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(lpht_pkg::SLOTS - 1)) begin
                        r_st       <= ST_IDLE;
                        r_new_slot <= 1'b0;
                        if (r_req.mode == lpht_pkg::MODE_CLEAR && r_new_slot) begin
                            o_valid <= 1'b1;
                        end
                    end
                end
                ST_IDLE: begin
                    if (i_req_valid && o_req_take) begin
                        r_req  <= i_req;
                        r_idx  <= i_req.home_slot;
                        r_n    <= '0;
                        r_tomb <= 1'b0;
                        if (i_req.mode == lpht_pkg::MODE_CLEAR) begin
                            r_st <= ST_CLR; r_clr <= '0; r_used <= '0;
                            r_new_slot <= 1'b1;
                            o_hit <= 1'b0; o_status <= 1'b0; o_read_value <= '0;
                        end else begin
                            r_st <= ST_READ;
                        end
                    end
                end
                ST_READ: r_st <= ST_EVAL;
                ST_EVAL: begin
                    if (n_done) begin
                        o_hit <= n_hit; o_status <= n_status; o_read_value <= '0;
                        if (kind_we && key_we && !r_tomb) r_used <= r_used + 1'b1;
                        if (n_rd) r_st <= ST_DATA;
                        else begin o_valid <= 1'b1; r_st <= ST_IDLE; end
                    end else begin
                        if (kind_rd == lpht_pkg::KIND_TOMB && !r_tomb) begin
                            r_tomb <= 1'b1; r_tomb_at <= r_idx;
                        end
                        r_idx <= r_idx + 1'b1;
                        r_n   <= r_n + 1'b1;
                        r_st  <= ST_READ;
                    end
                end
                ST_DATA: r_st <= ST_WAIT;
                ST_WAIT: begin
                    o_read_value <= data_rd; o_valid <= 1'b1; r_st <= ST_IDLE;
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
